FILE: hw/rtl/gat_pkg.sv
`timescale 1ns / 1ps
package gat_pkg;

  localparam int PairCount = 11;
  localparam int MaxOut    = 3;
  localparam int AddrWidth = 3;
  localparam int DataWidth = 32;

  typedef logic [7:0] byte_t;
  typedef logic [$clog2(PairCount)-1:0] pair_idx_t;

  // register index as seen in paddr[AddrWidth-1:2]
  typedef logic [AddrWidth-3:0] reg_idx_t;
  localparam reg_idx_t RegDirection = 1'b0;

  // direction codes
  localparam logic DirToTonos = 1'b0;
  localparam logic DirToOxia  = 1'b1;

  typedef struct packed {
    logic [0:2][7:0] seq;
    logic [1:0]      len;
  } pat_t;

  // results of one item handed from the matcher to the output slot
  typedef struct packed {
    logic [0:MaxOut-1][7:0] bytes;
    logic [1:0]             cnt;
    logic                   text_end;
  } res_t;

  localparam pat_t OXIA_PAT [0:PairCount-1] = '{
    '{seq: '{8'hCD, 8'hBE, 8'h00}, len: 2'd2},
    '{seq: '{8'hCE, 8'h87, 8'h00}, len: 2'd2},
    '{seq: '{8'hE1, 8'hBD, 8'hB1}, len: 2'd3},
    '{seq: '{8'hE1, 8'hBD, 8'hB3}, len: 2'd3},
    '{seq: '{8'hE1, 8'hBD, 8'hB5}, len: 2'd3},
    '{seq: '{8'hE1, 8'hBD, 8'hB7}, len: 2'd3},
    '{seq: '{8'hE1, 8'hBD, 8'hB9}, len: 2'd3},
    '{seq: '{8'hE1, 8'hBD, 8'hBB}, len: 2'd3},
    '{seq: '{8'hE1, 8'hBD, 8'hBD}, len: 2'd3},
    '{seq: '{8'hE1, 8'hBF, 8'h93}, len: 2'd3},
    '{seq: '{8'hE1, 8'hBF, 8'hA3}, len: 2'd3}
  };

  localparam pat_t TONOS_PAT [0:PairCount-1] = '{
    '{seq: '{8'h3B, 8'h00, 8'h00}, len: 2'd1},
    '{seq: '{8'hC2, 8'hB7, 8'h00}, len: 2'd2},
    '{seq: '{8'hCE, 8'hAC, 8'h00}, len: 2'd2},
    '{seq: '{8'hCE, 8'hAD, 8'h00}, len: 2'd2},
    '{seq: '{8'hCE, 8'hAE, 8'h00}, len: 2'd2},
    '{seq: '{8'hCE, 8'hAF, 8'h00}, len: 2'd2},
    '{seq: '{8'hCF, 8'h8C, 8'h00}, len: 2'd2},
    '{seq: '{8'hCF, 8'h8D, 8'h00}, len: 2'd2},
    '{seq: '{8'hCF, 8'h8E, 8'h00}, len: 2'd2},
    '{seq: '{8'hCE, 8'h90, 8'h00}, len: 2'd2},
    '{seq: '{8'hCE, 8'hB0, 8'h00}, len: 2'd2}
  };

endpackage

FILE: hw/rtl/gat_in_if.sv
`timescale 1ns / 1ps
interface gat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_end;

  modport source (output valid, output in_byte, output text_end, input ready);
  modport sink (input valid, input in_byte, input text_end, output ready);
endinterface

FILE: hw/rtl/gat_out_if.sv
`timescale 1ns / 1ps
interface gat_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       out_text_end;

  modport source (output valid, output out_byte, output run_last, output out_text_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input out_text_end,
                output ready);
endinterface

FILE: hw/rtl/greek_accent_utf8_transcoder_core.sv
`timescale 1ns / 1ps
// greek accent transcoder: swaps oxia and tonos forms in a utf-8 byte stream
// in_ch carries one byte per item with text_end on the last byte of a text;
// out_ch carries one byte per item with run_last on the last byte caused by
// an input byte and out_text_end on the final byte of a text
// the apb port holds the direction register at address 0 (0 oxia to tonos,
// 1 tonos to oxia); write it only while no item is in flight
// an item is registered in the input stage, then in the output slot
// throughput: one item per cycle while out_ch is ready and each byte yields at
// most one result; a byte that completes or breaks a sequence yields up to three
// results and holds the input until the single output slot, draining one byte
// a cycle, has sent them; held partial-match bytes produce nothing until resolved
// reset clears the direction, the held match and all valid flags
// when out_ch stalls the output slot holds its byte and the input stage
// fills, then in_ch ready drops; nothing is dropped or repeated
module greek_accent_utf8_transcoder_core
  import gat_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  gat_in_if.sink               in_ch,
  gat_out_if.source            out_ch
);

  logic direction;
  logic res_valid;
  logic res_ready;
  res_t res;

  gat_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .direction (direction)
  );

  gat_step u_step (
    .clk       (clk),
    .rst       (rst),
    .direction (direction),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  gat_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_ch    (out_ch)
  );

endmodule

FILE: hw/rtl/gat_cfg.sv
`timescale 1ns / 1ps
module gat_cfg
  import gat_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output logic                 direction
);

  reg_idx_t reg_idx;
  logic     wr_en;

  assign reg_idx = paddr[AddrWidth-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DirToTonos;
    end else if (wr_en && reg_idx == RegDirection) begin
      direction <= pwdata[0];
    end
  end

  assign prdata = (reg_idx == RegDirection) ? DataWidth'(direction) : '0;

endmodule

FILE: hw/rtl/gat_step.sv
`timescale 1ns / 1ps
module gat_step
  import gat_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  direction,
  gat_in_if.sink in_ch,
  output logic  res_valid,
  input  logic  res_ready,
  output res_t  res
);

  logic       s1_valid;
  byte_t      s1_byte;
  logic       s1_end;
  logic       in_fire;
  logic       advance;

  logic [1:0] held_count;
  logic [1:0] held_count_next;
  byte_t      held_bytes [0:1];
  byte_t      held_bytes_next [0:1];

  byte_t      seq [0:2];
  logic [1:0] seq_len;

  logic       any_full;
  logic       any_pre;
  pair_idx_t  full_idx;
  logic       one_full;
  logic       one_pre;
  pair_idx_t  one_idx;
  pat_t       full_rep;
  pat_t       one_rep;

  function automatic res_t push(res_t r, byte_t b);
    res_t o;
    o = r;
    if (r.cnt != 2'd3) begin
      o.bytes[r.cnt] = b;
      o.cnt          = r.cnt + 2'd1;
    end
    return o;
  endfunction

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign advance     = s1_valid && res_ready;
  assign in_ch.ready = !s1_valid || res_ready;
  assign res_valid   = s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (res_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte <= in_ch.in_byte;
      s1_end  <= in_ch.text_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
    end else if (advance) begin
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held_bytes <= held_bytes_next;
    end
  end

  // held bytes followed by the new byte
  always_comb begin
    seq[0] = s1_byte;
    seq[1] = s1_byte;
    seq[2] = s1_byte;
    if (held_count != 2'd0) seq[0] = held_bytes[0];
    if (held_count == 2'd2) seq[1] = held_bytes[1];
    seq_len = held_count + 2'd1;
  end

  // compare against all pairs of the active side at once
  always_comb begin
    pat_t p;
    logic eq;
    any_full = 1'b0;
    any_pre  = 1'b0;
    full_idx = '0;
    one_full = 1'b0;
    one_pre  = 1'b0;
    one_idx  = '0;
    for (int i = 0; i < PairCount; i++) begin
      p  = (direction == DirToOxia) ? TONOS_PAT[i] : OXIA_PAT[i];
      eq = 1'b1;
      for (int k = 0; k < 3; k++) begin
        if (k < int'(seq_len) && p.seq[k] != seq[k]) eq = 1'b0;
      end
      if (eq && p.len == seq_len) begin
        any_full = 1'b1;
        full_idx = pair_idx_t'(i);
      end
      if (eq && p.len > seq_len) any_pre = 1'b1;
      if (p.seq[0] == s1_byte && p.len == 2'd1) begin
        one_full = 1'b1;
        one_idx  = pair_idx_t'(i);
      end
      if (p.seq[0] == s1_byte && p.len > 2'd1) one_pre = 1'b1;
    end
  end

  assign full_rep = (direction == DirToOxia) ? OXIA_PAT[full_idx] : TONOS_PAT[full_idx];
  assign one_rep  = (direction == DirToOxia) ? OXIA_PAT[one_idx] : TONOS_PAT[one_idx];

  always_comb begin
    res_t r;
    r               = '0;
    held_count_next = held_count;
    held_bytes_next = held_bytes;
    if (any_full) begin
      for (int k = 0; k < 3; k++) begin
        if (k < int'(full_rep.len)) r = push(r, full_rep.seq[k]);
      end
      held_count_next = 2'd0;
    end else if (any_pre && held_count != 2'd2) begin
      held_bytes_next[held_count[0]] = s1_byte;
      held_count_next                = held_count + 2'd1;
    end else begin
      // broken match: flush, then retry the byte on its own
      if (held_count != 2'd0) r = push(r, held_bytes[0]);
      if (held_count == 2'd2) r = push(r, held_bytes[1]);
      held_count_next = 2'd0;
      if (one_full) begin
        if (held_count == 2'd2) begin
          r = push(r, s1_byte);
        end else begin
          for (int k = 0; k < 3; k++) begin
            if (k < int'(one_rep.len)) r = push(r, one_rep.seq[k]);
          end
        end
      end else if (one_pre) begin
        held_bytes_next[0] = s1_byte;
        held_count_next    = 2'd1;
      end else begin
        r = push(r, s1_byte);
      end
    end
    if (s1_end) begin
      if (held_count_next != 2'd0) r = push(r, held_bytes_next[0]);
      if (held_count_next == 2'd2) r = push(r, held_bytes_next[1]);
      held_count_next = 2'd0;
    end
    r.text_end = s1_end;
    res        = r;
  end

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    held_count != 2'd3)
    else $error("held count out of range");

  a_end_flush: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_end) |=> held_count == 2'd0)
    else $error("held bytes left after end of text");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !res_ready) |=> (s1_valid && $stable(s1_byte) && $stable(held_count)))
    else $error("input stage lost an item while stalled");

endmodule

FILE: hw/rtl/gat_outbuf.sv
`timescale 1ns / 1ps
module gat_outbuf
  import gat_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  res_valid,
  output logic  res_ready,
  input  res_t  res,
  gat_out_if.source out_ch
);

  logic [0:MaxOut-1][7:0] slot_bytes;
  logic                   slot_end;
  logic [1:0]             slot_cnt;
  logic [1:0]             slot_pos;
  logic                   busy;
  logic                   last;
  logic                   out_fire;

  assign busy      = slot_cnt != 2'd0;
  assign last      = slot_pos == (slot_cnt - 2'd1);
  assign out_fire  = out_ch.valid && out_ch.ready;
  assign res_ready = !busy || (out_fire && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_cnt <= 2'd0;
      slot_pos <= 2'd0;
    end else if (res_ready) begin
      slot_cnt <= res_valid ? res.cnt : 2'd0;
      slot_pos <= 2'd0;
    end else if (out_fire) begin
      slot_pos <= slot_pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      slot_bytes <= res.bytes;
      slot_end   <= res.text_end;
    end
  end

  assign out_ch.valid        = busy;
  assign out_ch.out_byte     = slot_bytes[slot_pos];
  assign out_ch.run_last     = last;
  assign out_ch.out_text_end = last && slot_end;

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> slot_pos < slot_cnt)
    else $error("slot read position past count");

  a_step_on: assert property (@(posedge clk) disable iff (rst)
    (out_fire && !last) |=> (busy && slot_pos == $past(slot_pos) + 2'd1))
    else $error("slot did not advance to the next byte");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=>
      (out_ch.valid && $stable(out_ch.out_byte) && $stable(out_ch.run_last)))
    else $error("output item changed while stalled");

endmodule

FILE: tb/sv/greek_accent_utf8_transcoder_core_test.sv
`timescale 1ns / 1ps
module greek_accent_utf8_transcoder_core_test
  import gat_pkg::*;
;

  typedef enum int {MatchNone, MatchPrefix, MatchFull} match_e;

  typedef struct packed {
    logic [23:0] seq;
    logic [1:0]  len;
  } form_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       out_text_end;
  } out_item_t;

  localparam reg_idx_t RegUnused = 1'b1;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  gat_in_if  in_ch ();
  gat_out_if out_ch ();

  greek_accent_utf8_transcoder_core i_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_ch(in_ch), .out_ch(out_ch)
  );

  // oxia forms and their tonos counterparts, first byte in the top bits
  form_t oxia_form [PairCount] = '{
    '{24'hCDBE00, 2'd2}, '{24'hCE8700, 2'd2}, '{24'hE1BDB1, 2'd3}, '{24'hE1BDB3, 2'd3},
    '{24'hE1BDB5, 2'd3}, '{24'hE1BDB7, 2'd3}, '{24'hE1BDB9, 2'd3}, '{24'hE1BDBB, 2'd3},
    '{24'hE1BDBD, 2'd3}, '{24'hE1BF93, 2'd3}, '{24'hE1BFA3, 2'd3}
  };
  form_t tonos_form [PairCount] = '{
    '{24'h3B0000, 2'd1}, '{24'hC2B700, 2'd2}, '{24'hCEAC00, 2'd2}, '{24'hCEAD00, 2'd2},
    '{24'hCEAE00, 2'd2}, '{24'hCEAF00, 2'd2}, '{24'hCF8C00, 2'd2}, '{24'hCF8D00, 2'd2},
    '{24'hCF8E00, 2'd2}, '{24'hCE9000, 2'd2}, '{24'hCEB000, 2'd2}
  };

  // transcoder state as the block should hold it
  logic       cur_direction = DirToTonos;
  logic [7:0] held_byte [2];
  int         held_cnt = 0;

  logic [7:0] step_bytes [$];
  out_item_t  expected_out [$];

  int   mismatch_count  = 0;
  int   items_sent      = 0;
  int   results_checked = 0;
  int   hold_off_cycles = 0;
  logic no_idle         = 1'b0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 30) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic int draw_wait();
    if (no_idle || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  // match s (first n bytes, top aligned) against the forms being converted
  function automatic match_e match_kind(input logic [23:0] s, input int n, output int hit);
    match_e found;
    form_t fm;
    logic [23:0] mask;
    found = MatchNone;
    hit = 0;
    mask = ~(24'hFFFFFF >> (8 * n));
    for (int i = 0; i < PairCount; i++) begin
      fm = (cur_direction == DirToOxia) ? tonos_form[i] : oxia_form[i];
      if (n > fm.len) continue;
      if ((fm.seq & mask) != (s & mask)) continue;
      if (n == fm.len) begin
        hit = i;
        return MatchFull;
      end
      found = MatchPrefix;
    end
    return found;
  endfunction

  function automatic void add_counterpart(input int i);
    form_t fm;
    fm = (cur_direction == DirToOxia) ? oxia_form[i] : tonos_form[i];
    for (int k = 0; k < fm.len; k++) step_bytes.push_back(fm.seq[23-8*k -: 8]);
  endfunction

  function automatic void spill_held();
    for (int k = 0; k < held_cnt; k++) step_bytes.push_back(held_byte[k]);
    held_cnt = 0;
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic e);
    logic [23:0] s;
    match_e kind;
    int hit, flushed, n;
    out_item_t item;
    step_bytes.delete();
    s = {b, 16'h0};
    if (held_cnt == 1) s = {held_byte[0], b, 8'h0};
    else if (held_cnt == 2) s = {held_byte[0], held_byte[1], b};
    kind = match_kind(s, held_cnt + 1, hit);
    if (kind == MatchFull) begin
      add_counterpart(hit);
      held_cnt = 0;
    end else if (kind == MatchPrefix && held_cnt < 2) begin
      held_byte[held_cnt] = b;
      held_cnt++;
    end else begin
      flushed = held_cnt;
      spill_held();
      kind = match_kind({b, 16'h0}, 1, hit);
      if (kind == MatchFull) begin
        // after two flushed bytes a one-byte form passes unchanged
        if (flushed == 2) step_bytes.push_back(b);
        else add_counterpart(hit);
      end else if (kind == MatchPrefix) begin
        held_byte[0] = b;
        held_cnt = 1;
      end else begin
        step_bytes.push_back(b);
      end
    end
    if (e) spill_held();
    n = (step_bytes.size() > MaxOut) ? MaxOut : step_bytes.size();
    for (int k = 0; k < n; k++) begin
      item.out_byte     = step_bytes[k];
      item.run_last     = (k == n - 1);
      item.out_text_end = (k == n - 1) && e;
      expected_out.push_back(item);
    end
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == RegDirection) cur_direction = data[0];
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(input reg_idx_t idx, input logic [31:0] want);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) report_mismatch($sformatf("register read %h, want %h", prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic e);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.in_byte  <= b;
    in_ch.text_end <= e;
    do @(posedge clk); while (!in_ch.ready);
    predict_byte(b, e);
    items_sent++;
  endtask

  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_out.size() != 0);
  endtask

  // a held partial match yields nothing, so give the pipeline time to settle
  task automatic quiesce();
    wait_results_done();
    repeat (8) @(posedge clk);
  endtask

  // one piece of text: a whole form, a cut-off form, or a plain byte
  task automatic send_piece();
    int pick, i, cut;
    logic e, sel_oxia;
    form_t fm;
    pick = $urandom_range(0, 9);
    i = $urandom_range(0, PairCount - 1);
    e = ($urandom_range(0, 9) == 0);
    sel_oxia = (cur_direction == DirToTonos) ^ (pick == 5);
    fm = sel_oxia ? oxia_form[i] : tonos_form[i];
    case (pick)
      0, 1, 2, 3, 4, 5: begin
        for (int k = 0; k < fm.len; k++) send_byte(fm.seq[23-8*k -: 8], e && k == fm.len - 1);
      end
      6: begin
        cut = (fm.len > 1) ? $urandom_range(1, fm.len - 1) : 1;
        for (int k = 0; k < cut; k++) send_byte(fm.seq[23-8*k -: 8], 1'b0);
        send_byte(8'($urandom_range(0, 255)), e);
      end
      7, 8: send_byte(8'($urandom_range(8'h20, 8'h7E)), e);
      default: send_byte(8'($urandom_range(0, 255)), e);
    endcase
  endtask

  task automatic test_register_access();
    write_reg(RegDirection, 32'hFFFF_FFFE);
    check_reg(RegDirection, 32'h0);
    write_reg(RegDirection, 32'h0000_0001);
    check_reg(RegDirection, 32'h1);
    // the spare index must not touch the direction
    write_reg(RegUnused, 32'hFFFF_FFFF);
    check_reg(RegDirection, 32'h1);
    write_reg(RegUnused, 32'h0);
    check_reg(RegDirection, 32'h1);
  endtask

  task automatic test_oxia_forms();
    quiesce();
    write_reg(RegDirection, {31'b0, DirToTonos});
    send_byte(8'hE1, 1'b0); send_byte(8'hBD, 1'b0); send_byte(8'hB1, 1'b0);
    send_byte(8'hCD, 1'b0); send_byte(8'hBE, 1'b0);
    send_byte(8'hE1, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hA3, 1'b1);
    // broken three-byte form
    send_byte(8'hE1, 1'b0); send_byte(8'hBD, 1'b0); send_byte(8'h41, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0);
    // end of text while two bytes are held
    send_byte(8'hE1, 1'b0); send_byte(8'hBD, 1'b1);
    wait_results_done();
  endtask

  task automatic test_tonos_forms();
    quiesce();
    write_reg(RegDirection, {31'b0, DirToOxia});
    send_byte(8'h3B, 1'b0);
    send_byte(8'hCE, 1'b0); send_byte(8'hAC, 1'b0);
    send_byte(8'hCE, 1'b0); send_byte(8'hFF, 1'b1);
    send_byte(8'hCE, 1'b1);
    wait_results_done();
  endtask

  task automatic test_direction_switch();
    quiesce();
    write_reg(RegDirection, {31'b0, DirToTonos});
    send_byte(8'hE1, 1'b0); send_byte(8'hBD, 1'b0);
    quiesce();
    // two held bytes flushed, then a lone semicolon passes through
    write_reg(RegDirection, {31'b0, DirToOxia});
    send_byte(8'h3B, 1'b0);
    send_byte(8'hCE, 1'b0);
    quiesce();
    write_reg(RegDirection, {31'b0, DirToTonos});
    send_byte(8'h87, 1'b1);
    wait_results_done();
  endtask

  task automatic test_random_text(input logic dir, input int count);
    int start;
    quiesce();
    write_reg(RegDirection, ($urandom() & 32'hFFFF_FFFE) | {31'b0, dir});
    start = items_sent;
    while (items_sent - start < count) begin
      send_piece();
      if ($urandom_range(0, 15) == 0) no_idle = !no_idle;
      if ($urandom_range(0, 59) == 0) wait_results_done();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_output_hold();
    int start;
    no_idle = 1'b1;
    hold_off_cycles = 80;
    start = items_sent;
    while (items_sent - start < 40) send_piece();
    wait_results_done();
    no_idle = 1'b0;
  endtask

  // receiver: per-item stall, plus a long hold when asked
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        stall = draw_wait();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid && hold_off_cycles == 0);
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_checked++;
      if (expected_out.size() == 0) begin
        report_mismatch($sformatf("unexpected item, byte %h", out_ch.out_byte));
      end else begin
        want = expected_out.pop_front();
        if (out_ch.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %h, want %h", out_ch.out_byte, want.out_byte));
        if (out_ch.run_last !== want.run_last)
          report_mismatch($sformatf("run_last %b, want %b on byte %h",
                                    out_ch.run_last, want.run_last, want.out_byte));
        if (out_ch.out_text_end !== want.out_text_end)
          report_mismatch($sformatf("out_text_end %b, want %b on byte %h",
                                    out_ch.out_text_end, want.out_text_end, want.out_byte));
      end
    end
  end

  initial begin : run_limit
    #5_000_000;
    $display("FAIL greek_accent_utf8_transcoder_core");
    $finish;
  end

  initial begin : main_flow
    int cycles;
    rst            <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.in_byte  <= 8'h00;
    in_ch.text_end <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_register_access();
    test_oxia_forms();
    test_tonos_forms();
    test_direction_switch();
    test_random_text(DirToTonos, 150);
    test_random_text(DirToOxia, 150);
    test_output_hold();
    test_random_text(DirToTonos, 120);

    in_ch.valid <= 1'b0;
    cycles = 0;
    while (expected_out.size() != 0 && cycles < 5000) begin
      @(posedge clk);
      cycles++;
    end
    repeat (10) @(posedge clk);
    if (expected_out.size() != 0)
      report_mismatch($sformatf("%0d expected items never arrived", expected_out.size()));

    $display("checked %0d output bytes from %0d input bytes in both directions",
             results_checked, items_sent);
    $display("with mid-match direction changes, an 80-cycle output hold and drain pauses");
    if (mismatch_count == 0) begin
      $display("PASS greek_accent_utf8_transcoder_core");
    end else begin
      $display("FAIL greek_accent_utf8_transcoder_core");
    end
    $finish;
  end

endmodule
